// ===== rtl/fpcd_pkg.sv =====
package fpcd_pkg;

  // Geometry and field widths
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int RADIUS          = 3;
  localparam int SLOTS           = 2 * RADIUS;
  localparam int SLOT_W          = 3;
  localparam int PIX_W           = 8;
  localparam int ROW_W           = 12;
  localparam int OUT_COL_W       = 10;
  localparam int THR_W           = 8;
  localparam int CFG_WIDTH_W     = 11;
  localparam int CFG_HEIGHT_W    = 13;
  localparam int CFG_DATA_W      = 13;
  localparam int CFG_IDX_W       = 2;
  localparam int MIN_SIZE        = 7;
  localparam int MAX_HEIGHT      = 4096;

  // Register reset values
  localparam int THR_RESET    = 20;
  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 4096;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [ROW_W-1:0]     corner_row;
    logic [OUT_COL_W-1:0] corner_col;
  } out_beat_t;

  // One testable centre with its four ring samples
  typedef struct packed {
    logic [PIX_W-1:0]     centre;
    logic [PIX_W-1:0]     far_up;
    logic [PIX_W-1:0]     near_left;
    logic [PIX_W-1:0]     near_down;
    logic [PIX_W-1:0]     newest;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
  } cand_t;

  // Add two line-buffer slot numbers modulo SLOTS (sum of inputs below 2*SLOTS)
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (SLOT_W+1)'(SLOTS)) sum = sum - (SLOT_W+1)'(SLOTS);
    return sum[SLOT_W-1:0];
  endfunction

  // Ring point counts when |centre - ring| exceeds the threshold
  function automatic logic ring_hit(input logic [PIX_W-1:0] ctr,
                                    input logic [PIX_W-1:0] ring,
                                    input logic [THR_W-1:0] thr);
    logic [PIX_W-1:0] diff;
    diff = (ctr > ring) ? (ctr - ring) : (ring - ctr);
    return diff > thr;
  endfunction

endpackage

// ===== rtl/fpcd_ram.sv =====
module fpcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ===== rtl/fpcd_front.sv =====
module fpcd_front #(
  parameter int MAX_WIDTH   = fpcd_pkg::MAX_WIDTH_DEF,
  parameter int QUEUE_DEPTH = fpcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  fpcd_pkg::in_beat_t                   in_data,
  input  logic [fpcd_pkg::CFG_WIDTH_W-1:0]     eff_width,
  input  logic [fpcd_pkg::CFG_HEIGHT_W-1:0]    eff_height,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     q_level,
  output logic                                 q_push,
  output fpcd_pkg::cand_t                      q_push_data
);

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WIDE_W = ((COL_W + 1) > fpcd_pkg::CFG_WIDTH_W) ?
                          (COL_W + 2) : (fpcd_pkg::CFG_WIDTH_W + 1);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW     = fpcd_pkg::SLOT_W;
  localparam int RW     = fpcd_pkg::ROW_W;

  // Slot distance from the current row's slot, per ring role
  localparam logic [SW-1:0] D_FAR    = '0;
  localparam logic [SW-1:0] D_LEFT   = SW'(fpcd_pkg::RADIUS - 1);
  localparam logic [SW-1:0] D_CENTRE = SW'(fpcd_pkg::RADIUS);
  localparam logic [SW-1:0] D_DOWN   = SW'(fpcd_pkg::RADIUS + 1);

  logic [RW-1:0]    row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [SW-1:0]    slot_r, slot_nxt;

  logic [RW-1:0]     cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [SW-1:0]     cur_slot;
  logic [WIDE_W-1:0] col_ext, width_ext;
  logic              accept, testable, last_col, last_row;

  logic [COL_W-1:0]           rd_addr [fpcd_pkg::SLOTS];
  logic                       wr_en   [fpcd_pkg::SLOTS];
  logic [fpcd_pkg::PIX_W-1:0] rd_data [fpcd_pkg::SLOTS];

  logic                                  s1_test_r;
  logic [SW-1:0]                         s1_slot_r;
  logic [fpcd_pkg::PIX_W-1:0]            s1_pix_r;
  logic [RW-1:0]                         s1_row_r;
  logic [fpcd_pkg::OUT_COL_W-1:0]        s1_col_r;

  // Position of this beat; frame start forces (0,0)
  assign cur_row  = in_data.frame_start ? '0 : row_r;
  assign cur_col  = in_data.frame_start ? '0 : col_r;
  assign cur_slot = in_data.frame_start ? '0 : slot_r;

  assign col_ext   = WIDE_W'(cur_col);
  assign width_ext = WIDE_W'(eff_width);

  // Room is kept for the candidate already in flight
  assign in_ready = ({1'b0, q_level} + (CNT_W+1)'(s1_test_r)) < (CNT_W+1)'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  // This pixel completes centre (r-3, c+1) when that centre is inside the border
  assign testable = (cur_row >= RW'(fpcd_pkg::SLOTS)) &&
                    ({1'b0, cur_row} < eff_height) &&
                    (col_ext < width_ext) &&
                    (col_ext + WIDE_W'(1) >= WIDE_W'(fpcd_pkg::RADIUS)) &&
                    (col_ext + WIDE_W'(1 + fpcd_pkg::RADIUS) < width_ext);

  // Raster position advance
  assign last_col = (col_ext + WIDE_W'(1)) >= width_ext;
  assign last_row = ({1'b0, cur_row} + (RW+1)'(1)) >= eff_height;

  always_comb begin
    col_nxt  = cur_col + COL_W'(1);
    row_nxt  = cur_row;
    slot_nxt = cur_slot;
    if (last_col) begin
      col_nxt = '0;
      if (last_row) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = cur_row + RW'(1);
        slot_nxt = fpcd_pkg::slot_add(cur_slot, SW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (accept) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end

  // Six line buffers, one per row slot
  for (genvar k = 0; k < fpcd_pkg::SLOTS; k++) begin : g_line
    localparam logic [SW-1:0] K = SW'(k);
    logic [SW-1:0] slot_gap;

    always_comb begin
      slot_gap = fpcd_pkg::slot_add(K, SW'(fpcd_pkg::SLOTS) - cur_slot);
      case (slot_gap)
        D_FAR:    rd_addr[k] = cur_col + COL_W'(fpcd_pkg::RADIUS - 1);
        D_LEFT:   rd_addr[k] = cur_col - COL_W'(fpcd_pkg::RADIUS - 1);
        D_CENTRE: rd_addr[k] = cur_col + COL_W'(1);
        D_DOWN:   rd_addr[k] = cur_col + COL_W'(fpcd_pkg::RADIUS + 1);
        default:  rd_addr[k] = cur_col;
      endcase
    end

    assign wr_en[k] = accept && (cur_slot == K);

    fpcd_ram #(
      .WIDTH (fpcd_pkg::PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk     (clk),
      .wr_en   (wr_en[k]),
      .wr_addr (cur_col),
      .wr_data (in_data.pixel),
      .rd_en   (accept),
      .rd_addr (rd_addr[k]),
      .rd_data (rd_data[k])
    );
  end

  // Stage that lines up the pixel with the line-buffer read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_test_r <= 1'b0;
    end else begin
      s1_test_r <= accept && testable;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_slot_r <= cur_slot;
      s1_pix_r  <= in_data.pixel;
      s1_row_r  <= cur_row - RW'(fpcd_pkg::RADIUS);
      s1_col_r  <= fpcd_pkg::OUT_COL_W'(col_ext + WIDE_W'(1));
    end
  end

  assign q_push = s1_test_r;

  always_comb begin
    q_push_data.centre    = rd_data[fpcd_pkg::slot_add(s1_slot_r, D_CENTRE)];
    q_push_data.far_up    = rd_data[s1_slot_r];
    q_push_data.near_left = rd_data[fpcd_pkg::slot_add(s1_slot_r, D_LEFT)];
    q_push_data.near_down = rd_data[fpcd_pkg::slot_add(s1_slot_r, D_DOWN)];
    q_push_data.newest    = s1_pix_r;
    q_push_data.row       = s1_row_r;
    q_push_data.col       = s1_col_r;
  end

`ifndef SYNTHESIS
  // A candidate only follows an accepted beat
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_test_r |-> $past(in_valid && in_ready))
    else $error("candidate without accepted beat");
`endif

endmodule

// ===== rtl/fpcd_queue.sv =====
module fpcd_queue #(
  parameter int DEPTH = fpcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  fpcd_pkg::cand_t            push_data,
  input  logic                       pop,
  output fpcd_pkg::cand_t            head,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fpcd_pkg::cand_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  // Circular storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign level     = count_r;

`ifndef SYNTHESIS
  // No overflow, no underflow
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CNT_W'(DEPTH)) || pop)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue underflow");
`endif

endmodule

// ===== rtl/fpcd_back.sv =====
module fpcd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [fpcd_pkg::THR_W-1:0]     threshold,
  input  fpcd_pkg::cand_t                q_head,
  input  logic                           q_not_empty,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fpcd_pkg::out_beat_t            out_data
);

  logic                h_up, h_new, h_left, h_down, corner;
  logic                out_valid_r, out_valid_nxt;
  fpcd_pkg::out_beat_t out_data_r;

  // Segment test: at least three of four ring points differ enough
  assign h_up   = fpcd_pkg::ring_hit(q_head.centre, q_head.far_up, threshold);
  assign h_new  = fpcd_pkg::ring_hit(q_head.centre, q_head.newest, threshold);
  assign h_left = fpcd_pkg::ring_hit(q_head.centre, q_head.near_left, threshold);
  assign h_down = fpcd_pkg::ring_hit(q_head.centre, q_head.near_down, threshold);
  assign corner = (h_up && h_new && h_left) || (h_up && h_new && h_down) ||
                  (h_up && h_left && h_down) || (h_new && h_left && h_down);

  // Take the next candidate whenever the output register is free
  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = corner;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && corner) begin
      out_data_r.corner_row <= q_head.row;
      out_data_r.corner_col <= q_head.col;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Reported centres sit at least the ring radius below the top border
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.corner_row >= fpcd_pkg::ROW_W'(fpcd_pkg::RADIUS))
    else $error("corner row inside top border");
`endif

endmodule

// ===== rtl/four_point_corner_detect_unit.sv =====
// Channel  Handshake                Beat contents
// in_      in_valid / in_ready      pixel, frame_start (raster order)
// out_     out_valid / out_ready    corner_row, corner_col
// cfg_     cfg_wr_en, cfg_index     cfg_data: threshold, width, height
//
// Takes one pixel per clock while in_ready is high; the rate is set by the six line buffers, each
// with one write and one registered read port per cycle.
// A corner passes the read stage and the queue before it shows on out_valid.
// rst_n (synchronous) clears position, queue and output; the line buffers are
// not cleared and their read data is only used after being written within the frame.
// in_ready drops when the queue plus the candidate in the read stage fill QUEUE_DEPTH.
module four_point_corner_detect_unit #(
  parameter int MAX_WIDTH   = fpcd_pkg::MAX_WIDTH_DEF,
  parameter int QUEUE_DEPTH = fpcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fpcd_pkg::in_beat_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fpcd_pkg::out_beat_t               out_data,
  input  logic                              cfg_wr_en,
  input  logic [fpcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpcd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int WIDTH_CAP = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
  localparam int WIDTH_RST = (fpcd_pkg::WIDTH_RESET < WIDTH_CAP) ?
                             fpcd_pkg::WIDTH_RESET : WIDTH_CAP;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int WW        = fpcd_pkg::CFG_WIDTH_W;
  localparam int HW        = fpcd_pkg::CFG_HEIGHT_W;

  logic [fpcd_pkg::THR_W-1:0] thr_r;
  logic [WW-1:0]              width_r;
  logic [HW-1:0]              height_r;
  logic [WW-1:0]              width_in;
  logic [HW-1:0]              height_in;

  fpcd_pkg::cand_t  push_data, head;
  logic             push, pop, not_empty;
  logic [CNT_W-1:0] level;

  // Size registers hold the clamped value
  assign width_in  = cfg_data[WW-1:0];
  assign height_in = cfg_data[HW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= fpcd_pkg::THR_W'(fpcd_pkg::THR_RESET);
      width_r  <= WW'(WIDTH_RST);
      height_r <= HW'(fpcd_pkg::HEIGHT_RESET);
    end else if (cfg_wr_en) begin
      case (fpcd_pkg::cfg_idx_t'(cfg_index))
        fpcd_pkg::CFG_THRESHOLD: thr_r <= cfg_data[fpcd_pkg::THR_W-1:0];
        fpcd_pkg::CFG_WIDTH: begin
          if (width_in < WW'(fpcd_pkg::MIN_SIZE)) width_r <= WW'(fpcd_pkg::MIN_SIZE);
          else if (width_in > WW'(WIDTH_CAP))     width_r <= WW'(WIDTH_CAP);
          else                                    width_r <= width_in;
        end
        fpcd_pkg::CFG_HEIGHT: begin
          if (height_in < HW'(fpcd_pkg::MIN_SIZE)) height_r <= HW'(fpcd_pkg::MIN_SIZE);
          else if (height_in > HW'(fpcd_pkg::MAX_HEIGHT)) begin
            height_r <= HW'(fpcd_pkg::MAX_HEIGHT);
          end else begin
            height_r <= height_in;
          end
        end
        default: ;
      endcase
    end
  end

  fpcd_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .eff_width   (width_r),
    .eff_height  (height_r),
    .q_level     (level),
    .q_push      (push),
    .q_push_data (push_data)
  );

  fpcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .level     (level)
  );

  fpcd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .threshold   (thr_r),
    .q_head      (head),
    .q_not_empty (not_empty),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
